### rtl/ersp_pkg.sv
`timescale 1ns / 1ps
package ersp_pkg;

	localparam int SQRT_STEPS = 32;
	localparam int DIV_STEPS = 32;

	localparam logic [60:0] PARALLEL_SQ_LIMIT = 61'd7205760;
	localparam logic signed [16:0] NO_EDGE_SCORE = -17'sd32768;
	localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFF;
	localparam logic [23:0] LIMIT_RESET = 24'd9830;
	localparam logic signed [15:0] DIR_MAX = 16'sd16384;

	typedef struct packed {
		logic signed [31:0] centre_a_x;
		logic signed [31:0] centre_a_y;
		logic signed [31:0] centre_a_z;
		logic signed [15:0] dir_a_x;
		logic signed [15:0] dir_a_y;
		logic signed [15:0] dir_a_z;
		logic signed [31:0] centre_b_x;
		logic signed [31:0] centre_b_y;
		logic signed [31:0] centre_b_z;
		logic signed [15:0] dir_b_x;
		logic signed [15:0] dir_b_y;
		logic signed [15:0] dir_b_z;
	} in_item_t;

	typedef struct packed {
		logic signed [16:0] edge_score;
		logic [31:0] line_distance;
		logic used_parallel_path;
	} out_item_t;

	typedef struct packed {
		logic par;
		logic over;
		logic [63:0] dcm;
	} sq_side_t;

	typedef struct packed {
		logic par;
		logic flag;
		logic [31:0] line_dist;
	} dv_side_t;

	function automatic logic signed [15:0] clamp_dir(input logic signed [15:0] v);
		logic signed [15:0] r;
		r = v;
		if (v > DIR_MAX) begin
			r = DIR_MAX;
		end else if (v < -DIR_MAX) begin
			r = -DIR_MAX;
		end
		return r;
	endfunction

endpackage

### rtl/epipolar_ray_pair_score.sv
`timescale 1ns / 1ps
// Scores a pair of viewing rays by the shortest distance between their 3D lines and
// accepts one pair per clock while the pipeline is not stalled. Registered front stages
// form the difference vector, the cross products and the sums of squares, a 32-stage
// pipelined square root follows, then a 32-stage divider forms the distance and a
// second 32-stage divider forms the score. A stall while the output holds a result
// freezes the whole pipeline, and no transfer is lost.
module epipolar_ray_pair_score import ersp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input in_item_t in_data,
	output logic out_valid,
	input logic out_stall,
	output out_item_t out_data,
	input logic cfg_wr_en,
	input logic [23:0] cfg_wr_data
);

	logic en;
	logic [23:0] limit_q;

	logic fr_vld;
	logic [63:0] fr_x;
	sq_side_t fr_side;

	logic sq_vld;
	logic [31:0] sq_root;
	sq_side_t sq_side;

	logic vld_s39;
	logic [63:0] dvd_s39;
	logic [31:0] dvs_s39;
	dv_side_t side_s39;
	dv_side_t side1_n;

	logic d1_vld;
	logic [31:0] d1_quot;
	dv_side_t d1_side;
	logic [31:0] dist_n;
	logic [31:0] diff_n;

	logic vld_s72;
	logic [63:0] dvd_s72;
	dv_side_t side_s72;

	logic d2_vld;
	logic [31:0] d2_quot;
	dv_side_t d2_side;

	logic out_valid_q;
	out_item_t out_data_q;

	assign en = !out_valid_q || !out_stall;
	assign in_stall = !en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	ersp_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(in_valid),
		.in_data(in_data),
		.out_vld(fr_vld),
		.out_x(fr_x),
		.out_side(fr_side)
	);

	ersp_sqrt u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(fr_vld),
		.in_x(fr_x),
		.in_side(fr_side),
		.out_vld(sq_vld),
		.out_root(sq_root),
		.out_side(sq_side)
	);

	always_comb begin
		side1_n.par = sq_side.par;
		side1_n.flag = sq_side.dcm[63:32] >= sq_root;
		side1_n.line_dist = sq_side.over ? DIST_SAT : sq_root;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s39 <= 1'b0;
		end else if (en) begin
			vld_s39 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s39 <= side1_n;
			dvd_s39 <= sq_side.par ? 64'd0 : sq_side.dcm;
			dvs_s39 <= sq_side.par ? 32'd1 : sq_root;
		end
	end

	ersp_div u_div_dist (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s39),
		.in_dividend(dvd_s39),
		.in_divisor(dvs_s39),
		.in_side(side_s39),
		.out_vld(d1_vld),
		.out_quot(d1_quot),
		.out_side(d1_side)
	);

	always_comb begin
		if (d1_side.par) begin
			dist_n = d1_side.line_dist;
		end else if (d1_side.flag) begin
			dist_n = DIST_SAT;
		end else begin
			dist_n = d1_quot;
		end
		diff_n = {8'd0, limit_q} - dist_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s72 <= 1'b0;
		end else if (en) begin
			vld_s72 <= d1_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dvd_s72 <= {25'd0, diff_n[23:0], 15'd0};
			side_s72.par <= d1_side.par;
			side_s72.flag <= dist_n < {8'd0, limit_q};
			side_s72.line_dist <= dist_n;
		end
	end

	ersp_div u_div_score (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_vld(vld_s72),
		.in_dividend(dvd_s72),
		.in_divisor({8'd0, limit_q}),
		.in_side(side_s72),
		.out_vld(d2_vld),
		.out_quot(d2_quot),
		.out_side(d2_side)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= d2_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_data_q.edge_score <= d2_side.flag ? $signed(d2_quot[16:0]) : NO_EDGE_SCORE;
			out_data_q.line_distance <= d2_side.line_dist;
			out_data_q.used_parallel_path <= d2_side.par;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_data_q;

endmodule

### rtl/ersp_front.sv
`timescale 1ns / 1ps
module ersp_front import ersp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input in_item_t in_data,
	output logic out_vld,
	output logic [63:0] out_x,
	output sq_side_t out_side
);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6;

	logic signed [32:0] d_n [3];
	logic signed [15:0] a_n [3];
	logic signed [15:0] b_n [3];
	logic signed [32:0] d_s1 [3];
	logic signed [15:0] a_s1 [3];
	logic signed [15:0] b_s1 [3];

	logic signed [29:0] pc_n [3][2];
	logic signed [47:0] pe_n [3][2];
	logic signed [29:0] pc_s2 [3][2];
	logic signed [47:0] pe_s2 [3][2];
	logic signed [32:0] d_s2 [3];

	logic signed [30:0] c_n [3];
	logic signed [48:0] e_n [3];
	logic signed [30:0] c_s3 [3];
	logic signed [48:0] e_s3 [3];
	logic signed [32:0] d_s3 [3];

	logic signed [59:0] cc_n [3];
	logic signed [62:0] dcp_n [3];
	logic [33:0] m_n [3];
	logic signed [48:0] em [3];
	logic signed [59:0] cc_s4 [3];
	logic signed [62:0] dcp_s4 [3];
	logic [33:0] m_s4 [3];

	logic [60:0] csq_n;
	logic signed [64:0] dc_n;
	logic [63:0] msq_n [3];
	logic big_n;
	logic [60:0] csq_s5;
	logic signed [64:0] dc_s5;
	logic [63:0] msq_s5 [3];
	logic big_s5;

	logic [65:0] ssum;
	logic par_n;
	logic [64:0] dcm_n;
	logic [63:0] x_s6;
	sq_side_t side_s6;

	always_comb begin
		d_n[0] = {in_data.centre_a_x[31], in_data.centre_a_x}
			- {in_data.centre_b_x[31], in_data.centre_b_x};
		d_n[1] = {in_data.centre_a_y[31], in_data.centre_a_y}
			- {in_data.centre_b_y[31], in_data.centre_b_y};
		d_n[2] = {in_data.centre_a_z[31], in_data.centre_a_z}
			- {in_data.centre_b_z[31], in_data.centre_b_z};
		a_n[0] = clamp_dir(in_data.dir_a_x);
		a_n[1] = clamp_dir(in_data.dir_a_y);
		a_n[2] = clamp_dir(in_data.dir_a_z);
		b_n[0] = clamp_dir(in_data.dir_b_x);
		b_n[1] = clamp_dir(in_data.dir_b_y);
		b_n[2] = clamp_dir(in_data.dir_b_z);
	end

	always_comb begin
		pc_n[0][0] = a_s1[1] * b_s1[2];
		pc_n[0][1] = a_s1[2] * b_s1[1];
		pc_n[1][0] = a_s1[2] * b_s1[0];
		pc_n[1][1] = a_s1[0] * b_s1[2];
		pc_n[2][0] = a_s1[0] * b_s1[1];
		pc_n[2][1] = a_s1[1] * b_s1[0];
		pe_n[0][0] = d_s1[1] * a_s1[2];
		pe_n[0][1] = d_s1[2] * a_s1[1];
		pe_n[1][0] = d_s1[2] * a_s1[0];
		pe_n[1][1] = d_s1[0] * a_s1[2];
		pe_n[2][0] = d_s1[0] * a_s1[1];
		pe_n[2][1] = d_s1[1] * a_s1[0];
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			c_n[i] = {pc_s2[i][0][29], pc_s2[i][0]} - {pc_s2[i][1][29], pc_s2[i][1]};
			e_n[i] = {pe_s2[i][0][47], pe_s2[i][0]} - {pe_s2[i][1][47], pe_s2[i][1]};
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			cc_n[i] = c_s3[i] * c_s3[i];
			dcp_n[i] = d_s3[i] * c_s3[i];
			em[i] = e_s3[i][48] ? -e_s3[i] : e_s3[i];
			m_n[i] = em[i][47:14];
		end
	end

	always_comb begin
		csq_n = {1'b0, cc_s4[0]} + {1'b0, cc_s4[1]} + {1'b0, cc_s4[2]};
		dc_n = dcp_s4[0] + dcp_s4[1] + dcp_s4[2];
		big_n = 1'b0;
		for (int i = 0; i < 3; i++) begin
			msq_n[i] = m_s4[i][31:0] * m_s4[i][31:0];
			big_n = big_n | (|m_s4[i][33:32]);
		end
	end

	always_comb begin
		ssum = {2'b00, msq_s5[0]} + {2'b00, msq_s5[1]} + {2'b00, msq_s5[2]};
		par_n = csq_s5 < PARALLEL_SQ_LIMIT;
		dcm_n = dc_s5[64] ? 65'(-dc_s5) : 65'(dc_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s1 <= d_n;
			a_s1 <= a_n;
			b_s1 <= b_n;
			pc_s2 <= pc_n;
			pe_s2 <= pe_n;
			d_s2 <= d_s1;
			c_s3 <= c_n;
			e_s3 <= e_n;
			d_s3 <= d_s2;
			cc_s4 <= cc_n;
			dcp_s4 <= dcp_n;
			m_s4 <= m_n;
			csq_s5 <= csq_n;
			dc_s5 <= dc_n;
			msq_s5 <= msq_n;
			big_s5 <= big_n;
			x_s6 <= par_n ? ssum[63:0] : {3'b000, csq_s5};
			side_s6.par <= par_n;
			side_s6.over <= big_s5 | (|ssum[65:64]);
			side_s6.dcm <= dcm_n[63:0];
		end
	end

	assign out_vld = vld_s6;
	assign out_x = x_s6;
	assign out_side = side_s6;

endmodule

### rtl/ersp_sqrt.sv
`timescale 1ns / 1ps
module ersp_sqrt import ersp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [63:0] in_x,
	input sq_side_t in_side,
	output logic out_vld,
	output logic [31:0] out_root,
	output sq_side_t out_side
);

	logic vld_s [SQRT_STEPS+1];
	logic [63:0] x_s [SQRT_STEPS+1];
	logic [31:0] root_s [SQRT_STEPS+1];
	logic [33:0] rem_s [SQRT_STEPS+1];
	sq_side_t side_s [SQRT_STEPS+1];

	assign vld_s[0] = in_vld;
	assign x_s[0] = in_x;
	assign root_s[0] = '0;
	assign rem_s[0] = '0;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_step
		logic [35:0] r2;
		logic [35:0] trial;
		logic ge;

		always_comb begin
			r2 = {rem_s[g], x_s[g][63:62]};
			trial = {2'b00, root_s[g], 2'b01};
			ge = r2 >= trial;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				x_s[g+1] <= {x_s[g][61:0], 2'b00};
				rem_s[g+1] <= ge ? 34'(r2 - trial) : r2[33:0];
				root_s[g+1] <= {root_s[g][30:0], ge};
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld = vld_s[SQRT_STEPS];
	assign out_root = root_s[SQRT_STEPS];
	assign out_side = side_s[SQRT_STEPS];

endmodule

### rtl/ersp_div.sv
`timescale 1ns / 1ps
module ersp_div import ersp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_vld,
	input logic [63:0] in_dividend,
	input logic [31:0] in_divisor,
	input dv_side_t in_side,
	output logic out_vld,
	output logic [31:0] out_quot,
	output dv_side_t out_side
);

	logic vld_s [DIV_STEPS+1];
	logic [31:0] rem_s [DIV_STEPS+1];
	logic [31:0] low_s [DIV_STEPS+1];
	logic [31:0] dv_s [DIV_STEPS+1];
	dv_side_t side_s [DIV_STEPS+1];

	assign vld_s[0] = in_vld;
	assign rem_s[0] = in_dividend[63:32];
	assign low_s[0] = in_dividend[31:0];
	assign dv_s[0] = in_divisor;
	assign side_s[0] = in_side;

	for (genvar g = 0; g < DIV_STEPS; g++) begin : g_step
		logic [32:0] r2;
		logic ge;

		always_comb begin
			r2 = {rem_s[g], low_s[g][31]};
			ge = r2 >= {1'b0, dv_s[g]};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[g+1] <= 1'b0;
			end else if (en) begin
				vld_s[g+1] <= vld_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= ge ? 32'(r2 - {1'b0, dv_s[g]}) : r2[31:0];
				low_s[g+1] <= {low_s[g][30:0], ge};
				dv_s[g+1] <= dv_s[g];
				side_s[g+1] <= side_s[g];
			end
		end
	end

	assign out_vld = vld_s[DIV_STEPS];
	assign out_quot = low_s[DIV_STEPS];
	assign out_side = side_s[DIV_STEPS];

endmodule

### rtl/ersp_checker.sv
`timescale 1ns / 1ps
module ersp_checker import ersp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input out_item_t out_data
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("Stalled result changed or vanished.");

	a_back_pressure: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |-> in_stall)
		else $error("Input taken while the output is blocked.");

	a_score_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.edge_score != NO_EDGE_SCORE |->
			out_data.edge_score >= 17'sd0 && out_data.edge_score <= 17'sd32768)
		else $error("Score outside its range.");

	a_zero_dist: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.line_distance == 32'd0 |->
			out_data.edge_score == 17'sd32768 || out_data.edge_score == NO_EDGE_SCORE)
		else $error("Zero distance without full score.");

endmodule

bind epipolar_ray_pair_score ersp_checker u_ersp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.out_data(out_data)
);
